@@ src/olt_pkg.sv @@
// Package for the ordered list table engine.
// Holds the store depth, operation and status codes and the capacity clamp.
// No dependencies.
`default_nettype none
package olt_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		OP_APPEND    = 3'd0,
		OP_INSERT    = 3'd1,
		OP_OVERWRITE = 3'd2,
		OP_DELETE    = 3'd3,
		OP_READ      = 3'd4,
		OP_SEARCH    = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ENTRIES);

	// capacity register clamped to 1 .. MAX_ENTRIES
	function automatic logic [CNT_W-1:0] eff_capacity(input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] c;
		c = cap;
		if (c == '0) c = CNT_W'(1);
		if (c > CNT_W'(MAX_ENTRIES)) c = CNT_W'(MAX_ENTRIES);
		return c;
	endfunction

endpackage
`default_nettype wire

@@ src/olt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module olt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ src/ordered_list_table_engine.sv @@
// Ordered list table engine: one request per start pulse, one result per request.
// Rejects and unused codes are answered from idle; append and overwrite write once;
// read issues the address, then captures data; search compares each entry in turn
// to a hit or the last entry; insert and delete move entries by a read and a write each;
// insert then writes the new word. Next request may be accepted in the result cycle.
// Async reset: count 0, capacity 16; entry store is not cleared. No stall on results.
`default_nettype none
module ordered_list_table_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cap_we,
	input  wire logic [olt_pkg::CNT_W-1:0]   cap_wdata,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [2:0]                  func,
	input  wire logic [4:0]                  position,
	input  wire logic signed [31:0]          word_in,
	output logic                             done,
	output logic [1:0]                       status,
	output logic signed [31:0]               word_out,
	output logic                             hit,
	output logic [3:0]                       hit_position,
	output logic [olt_pkg::CNT_W-1:0]        entry_count,
	output logic                             is_empty,
	output logic                             is_full
);
	import olt_pkg::*;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,     // single write of word_q at idx_q
		S_SH_RD,     // read neighbor of idx_q
		S_SH_WR,     // write neighbor into idx_q
		S_SRCH_RD,   // read idx_q for compare
		S_SRCH_CMP,  // compare against word_q
		S_RD,        // read request: issue address
		S_RD_DATA    // read request: capture data
	} state_t;

	state_t             state_q;
	func_t              func_q;
	logic [4:0]         pos_q;
	logic [WORD_W-1:0]  word_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   cap_q;

	logic               done_q;
	status_t            status_q;
	logic [WORD_W-1:0]  word_out_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_pos_q;

	// RAM port signals
	logic               ram_we;
	logic [IDX_W-1:0]   ram_raddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;

	logic [CNT_W-1:0]   cap_eff;
	logic               full;
	func_t              func_in;
	logic [CNT_W-1:0]   idx_ext;

	assign cap_eff = eff_capacity(cap_q);
	assign full    = count_q >= cap_eff;
	assign func_in = func_t'(func);
	assign idx_ext = {1'b0, idx_q};

	// Read address: one step up for delete moves, one step down for
	// insert moves, otherwise the current index.
	always_comb begin
		ram_raddr = idx_q;
		if (state_q == S_SH_RD) begin
			ram_raddr = (func_q == OP_DELETE) ? idx_q + IDX_W'(1) : idx_q - IDX_W'(1);
		end
	end

	assign ram_we    = (state_q == S_WRITE) || (state_q == S_SH_WR);
	assign ram_wdata = (state_q == S_WRITE) ? word_q : ram_rdata;

	olt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// config register, to be written only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cap_we) begin
			cap_q <= cap_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			word_out_q <= '0;
			hit_q      <= 1'b0;
			hit_pos_q  <= '0;
			func_q     <= OP_APPEND;
			pos_q      <= '0;
			word_q     <= '0;
			idx_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q     <= func_in;
						pos_q      <= position;
						word_q     <= word_in;
						status_q   <= ST_OK;
						word_out_q <= '0;
						hit_q      <= 1'b0;
						hit_pos_q  <= '0;
						case (func_in)
							OP_APPEND: begin
								if (full) begin
									status_q <= ST_OVERFLOW;
									done_q   <= 1'b1;
								end else begin
									idx_q   <= count_q[IDX_W-1:0];
									state_q <= S_WRITE;
								end
							end
							OP_INSERT: begin
								if (position > count_q) begin
									status_q <= ST_BADPOS;
									done_q   <= 1'b1;
								end else if (full) begin
									status_q <= ST_OVERFLOW;
									done_q   <= 1'b1;
								end else if (position == count_q) begin
									idx_q   <= position[IDX_W-1:0];
									state_q <= S_WRITE;
								end else begin
									idx_q   <= count_q[IDX_W-1:0];
									state_q <= S_SH_RD;
								end
							end
							OP_OVERWRITE: begin
								if (position >= count_q) begin
									status_q <= ST_BADPOS;
									done_q   <= 1'b1;
								end else begin
									idx_q   <= position[IDX_W-1:0];
									state_q <= S_WRITE;
								end
							end
							OP_DELETE: begin
								if (position >= count_q) begin
									status_q <= ST_BADPOS;
									done_q   <= 1'b1;
								end else if (position + 5'd1 < count_q) begin
									idx_q   <= position[IDX_W-1:0];
									state_q <= S_SH_RD;
								end else begin
									// last entry: nothing to move
									count_q <= count_q - CNT_W'(1);
									done_q  <= 1'b1;
								end
							end
							OP_READ: begin
								if (position >= count_q) begin
									status_q <= ST_BADPOS;
									done_q   <= 1'b1;
								end else begin
									idx_q   <= position[IDX_W-1:0];
									state_q <= S_RD;
								end
							end
							OP_SEARCH: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									idx_q   <= '0;
									state_q <= S_SRCH_RD;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_WRITE: begin
					if (func_q == OP_APPEND || func_q == OP_INSERT) begin
						count_q <= count_q + CNT_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					if (func_q == OP_DELETE) begin
						idx_q <= idx_q + IDX_W'(1);
						if (idx_ext + CNT_W'(2) < count_q) begin
							state_q <= S_SH_RD;
						end else begin
							count_q <= count_q - CNT_W'(1);
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q - IDX_W'(1);
						if (idx_ext - CNT_W'(1) == pos_q) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_SH_RD;
						end
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (ram_rdata == word_q) begin
						hit_q     <= 1'b1;
						hit_pos_q <= idx_q;
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end else if (idx_ext + CNT_W'(1) == count_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_RD: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					word_out_q <= ram_rdata;
					done_q     <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result ports; count flags follow count_q, which is final in the strobe cycle
	assign busy         = state_q != S_IDLE;
	assign done         = done_q;
	assign status       = status_q;
	assign word_out     = signed'(word_out_q);
	assign hit          = hit_q;
	assign hit_position = hit_pos_q;
	assign entry_count  = count_q;
	assign is_empty     = count_q == '0;
	assign is_full      = full;

`ifndef SYNTHESIS
	// the count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above store depth");

	// no result strobe while the sequencer is working
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe while busy");

	// an accepted request is either in progress or answered next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("request accepted but dropped");

	// a rejected request leaves the count alone
	a_reject_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> $stable(count_q))
		else $error("rejected request changed the count");
`endif

endmodule
`default_nettype wire
